@@ hdl/sfd_pkg.sv @@
// Shared constants and the result type of the sensor frame deframer.
// Used by sfd_parse and sensor_frame_deframer_top; depends on nothing.
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] SOF_BYTE    = 8'hAA;
  localparam int         PAYLOAD_LEN = 9;
  // Start byte, length byte and checksum byte frame the payload.
  localparam int         FRAME_OVERHEAD = 3;
  localparam int         FRAME_TOTAL    = PAYLOAD_LEN + FRAME_OVERHEAD;

  localparam int         CNT_W = 4;
  localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_LEN);

  // Byte positions within a frame.
  localparam logic [CNT_W-1:0] POS_SOF        = 4'd0;
  localparam logic [CNT_W-1:0] POS_LEN        = 4'd1;
  localparam logic [CNT_W-1:0] POS_ID_FIRST   = 4'd2;
  localparam logic [CNT_W-1:0] POS_STATUS     = 4'd4;
  localparam logic [CNT_W-1:0] POS_TEMP_FIRST = 4'd5;
  localparam logic [CNT_W-1:0] POS_TIME_FIRST = 4'd7;
  localparam logic [CNT_W-1:0] POS_CHECK      = CNT_W'(FRAME_TOTAL - 1);
  localparam logic [CNT_W-1:0] COUNT_MAX      = CNT_W'(FRAME_TOTAL + 1);

  localparam int DATA_W = 72;

  typedef struct packed {
    logic [31:0]        tick_ms;
    logic signed [15:0] temperature_tenths;
    logic [7:0]         status_byte;
    logic [15:0]        node_id;
  } sfd_fields_t;

  typedef struct packed {
    logic        frame_ok;
    sfd_fields_t fields;
  } sfd_result_t;

endpackage

`default_nettype wire

@@ hdl/sensor_frame_deframer_top.sv @@
// Sensor frame deframer: takes one frame byte per item and, on the byte
// marked last, delivers an ok flag with the decoded payload fields. Every
// byte goes through the parser in the cycle it is accepted; the result of
// the last byte lands in the output register, so one byte is taken per
// clock while the result side keeps up; a result waiting on a stalled
// consumer holds the input only if the output register is full. The result
// is out in the cycle after its last byte. Uses sfd_pkg and sfd_parse.
`default_nettype none

module sensor_frame_deframer_top
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] data_byte
  input  wire logic              in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // [15:0] node_id, [23:16] status_byte,
                                             // [39:24] temperature_tenths, [71:40] tick_ms
  output logic                   out_tuser   // frame_ok
);

  logic        step;
  logic        res_valid;
  sfd_result_t res;
  logic        out_valid_r, out_valid_nxt;
  sfd_result_t out_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  sfd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_tdata),
    .last_byte    (in_tlast),
    .result_valid (res_valid),
    .result       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.fields;
  assign out_tuser  = out_r.frame_ok;

endmodule

`default_nettype wire

@@ hdl/sfd_parse.sv @@
// Frame parser: byte counter, payload checksum and field capture.
// Produces the decoded result on the final byte of a frame; uses sfd_pkg.
`default_nettype none

module sfd_parse
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  output sfd_result_t      result
);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_sum_r, running_sum_nxt;
  logic             header_good_r, header_good_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [15:0]      temp_r, temp_nxt;
  logic [31:0]      time_r, time_nxt;
  logic             ok;

  always_comb begin
    header_good_nxt = header_good_r;
    running_sum_nxt = running_sum_r;
    id_nxt          = id_r;
    status_nxt      = status_r;
    temp_nxt        = temp_r;
    time_nxt        = time_r;

    if (byte_count_r == POS_SOF) begin
      header_good_nxt = (data_byte == SOF_BYTE);
    end else if (byte_count_r == POS_LEN) begin
      header_good_nxt = header_good_r && (data_byte == LEN_BYTE);
    end else if (byte_count_r < POS_CHECK) begin
      running_sum_nxt = running_sum_r + data_byte;
      if (byte_count_r < POS_STATUS) begin
        id_nxt = {id_r[7:0], data_byte};
      end else if (byte_count_r == POS_STATUS) begin
        status_nxt = data_byte;
      end else if (byte_count_r < POS_TIME_FIRST) begin
        temp_nxt = {temp_r[7:0], data_byte};
      end else begin
        time_nxt = {time_r[23:0], data_byte};
      end
    end

    byte_count_nxt = (byte_count_r < COUNT_MAX) ? byte_count_r + 1'b1 : byte_count_r;

    // The checksum byte is compared against the sum of the nine payload bytes.
    ok = header_good_r && (byte_count_r == POS_CHECK) && (data_byte == running_sum_r);

    result_valid = step && last_byte;
    result.frame_ok = ok;
    if (ok) begin
      result.fields.node_id            = id_r;
      result.fields.status_byte        = status_r;
      result.fields.temperature_tenths = temp_r;
      result.fields.tick_ms            = time_r;
    end else begin
      result.fields = '0;
    end
  end

  // The final byte of any frame returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_count_r  <= '0;
      running_sum_r <= '0;
      header_good_r <= 1'b1;
      id_r          <= '0;
      status_r      <= '0;
      temp_r        <= '0;
      time_r        <= '0;
    end else if (step) begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      header_good_r <= header_good_nxt;
      id_r          <= id_nxt;
      status_r      <= status_nxt;
      temp_r        <= temp_nxt;
      time_r        <= time_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= COUNT_MAX)
    else $error("byte counter ran past its saturation value");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> byte_count_r == POS_SOF && header_good_r && running_sum_r == 8'd0)
    else $error("parser did not restart after the final byte");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    result_valid && !result.frame_ok |-> result.fields == '0)
    else $error("rejected frame carries nonzero fields");

endmodule

`default_nettype wire

@@ tb/tb_sensor_frame_deframer_top.sv @@
// Self-checking testbench for sensor_frame_deframer_top: streams good and damaged
// sensor frames byte by byte and compares every frame result with a local decoder.
// Depends on sfd_pkg and the deframer RTL.
`default_nettype none

module tb_sensor_frame_deframer_top;
  import sfd_pkg::*;

  localparam int RAND_BYTES   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;

  // Decodes frames exactly as the deframer should and holds the results still owed.
  class deframe_checker;
    logic [CNT_W-1:0] pos_cnt;
    logic [7:0]       sum_acc;
    bit               hdr_ok;
    sfd_fields_t      cap;
    sfd_result_t      expected_frames[$];
    int               errors;
    int               ok_frames;
    int               bad_frames;

    function new();
      clear_frame_state();
      errors     = 0;
      ok_frames  = 0;
      bad_frames = 0;
    endfunction

    function void clear_frame_state();
      pos_cnt = '0;
      sum_acc = '0;
      hdr_ok  = 1'b1;
      cap     = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic lst);
      sfd_result_t      r;
      logic [CNT_W-1:0] p;
      p = pos_cnt;
      if (p == POS_SOF) begin
        hdr_ok = (b == SOF_BYTE);
      end else if (p == POS_LEN) begin
        hdr_ok = hdr_ok && (b == LEN_BYTE);
      end else if (p < POS_CHECK) begin
        // Payload bytes arrive big-endian; bytes past the checksum slot are ignored.
        sum_acc = sum_acc + b;
        if (p < POS_STATUS) begin
          cap.node_id = {cap.node_id[7:0], b};
        end else if (p == POS_STATUS) begin
          cap.status_byte = b;
        end else if (p < POS_TIME_FIRST) begin
          cap.temperature_tenths = {cap.temperature_tenths[7:0], b};
        end else begin
          cap.tick_ms = {cap.tick_ms[23:0], b};
        end
      end
      if (pos_cnt < COUNT_MAX) pos_cnt = pos_cnt + 1'b1;
      if (lst) begin
        r.frame_ok = hdr_ok && (p == POS_CHECK) && (b == sum_acc);
        r.fields   = r.frame_ok ? cap : '0;
        expected_frames.push_back(r);
        clear_frame_state();
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic ok);
      sfd_fields_t got;
      sfd_result_t want;
      got = data;
      if (expected_frames.size() == 0) begin
        $error("frame result with no frame pending: frame_ok=%0b data=%h", ok, data);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (want.frame_ok) ok_frames++;
      else bad_frames++;
      if (ok !== want.frame_ok) begin
        $error("frame_ok: expected %0b, got %0b", want.frame_ok, ok);
        errors++;
      end
      if (got.node_id !== want.fields.node_id) begin
        $error("node_id: expected %h, got %h", want.fields.node_id, got.node_id);
        errors++;
      end
      if (got.status_byte !== want.fields.status_byte) begin
        $error("status_byte: expected %h, got %h", want.fields.status_byte,
               got.status_byte);
        errors++;
      end
      if (got.temperature_tenths !== want.fields.temperature_tenths) begin
        $error("temperature_tenths: expected %0d, got %0d",
               want.fields.temperature_tenths, got.temperature_tenths);
        errors++;
      end
      if (got.tick_ms !== want.fields.tick_ms) begin
        $error("tick_ms: expected %h, got %h", want.fields.tick_ms,
               got.tick_ms);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'h00;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;

  deframe_checker chk = new();
  logic [7:0]     frame_q[$];
  bit             quiet         = 1'b0;
  bit             hold_off_req  = 1'b0;
  int             bytes_sent    = 0;
  int             idle_cycles   = 0;

  sensor_frame_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none during quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) chk.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) chk.take_byte(in_tdata, in_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && $urandom_range(0, 99) < 15) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic void build_good(logic [15:0] id, logic [7:0] status,
                                     logic [15:0] temp, logic [31:0] stamp);
    logic [7:0] sum;
    frame_q = {SOF_BYTE, LEN_BYTE, id[15:8], id[7:0], status, temp[15:8], temp[7:0],
               stamp[31:24], stamp[23:16], stamp[15:8], stamp[7:0]};
    sum = '0;
    for (int i = POS_ID_FIRST; i < POS_CHECK; i++) sum = sum + frame_q[i];
    frame_q.push_back(sum);
  endfunction

  function automatic void build_random_good();
    build_good(16'($urandom), 8'($urandom), 16'($urandom), $urandom);
  endfunction

  initial begin
    int kind;
    int n;
    int frame_idx;
    int stop_at;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: field extremes, each rejection reason, wrong counts.
    build_good(16'h0000, 8'h00, 16'h0000, 32'h0000_0000);
    send_frame();
    build_good(16'hFFFF, 8'hFF, 16'h7FFF, 32'hFFFF_FFFF);
    send_frame();
    build_good(16'h8001, 8'h5A, 16'h8000, 32'h8000_0001);
    send_frame();
    build_random_good();
    frame_q[POS_SOF] = 8'h55;
    send_frame();
    build_random_good();
    frame_q[POS_LEN] = 8'd10;
    send_frame();
    build_random_good();
    frame_q[POS_CHECK] = frame_q[POS_CHECK] ^ 8'h01;
    send_frame();
    frame_q = {SOF_BYTE};
    send_frame();
    frame_q = {SOF_BYTE, LEN_BYTE};
    send_frame();
    build_random_good();
    void'(frame_q.pop_back());
    send_frame();
    build_random_good();
    frame_q.push_back(frame_q[POS_CHECK]);
    send_frame();
    // Long enough to run the byte counter into saturation.
    build_random_good();
    repeat (8) frame_q.push_back(8'($urandom));
    send_frame();
    build_random_good();
    send_frame();

    // Random frames; the result side holds off first so the input backs up.
    hold_off_req = 1'b1;
    frame_idx = 0;
    stop_at = bytes_sent + RAND_BYTES;
    while (bytes_sent < stop_at) begin
      quiet = (frame_idx % 40) >= 30;
      build_random_good();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed frame
      end else if (kind < 78) begin
        frame_q[POS_CHECK] = frame_q[POS_CHECK] + 8'($urandom_range(1, 255));
      end else if (kind < 82) begin
        frame_q[POS_SOF] = frame_q[POS_SOF] ^ 8'($urandom_range(1, 255));
      end else if (kind < 86) begin
        frame_q[POS_LEN] = frame_q[POS_LEN] ^ 8'($urandom_range(1, 255));
      end else if (kind < 90) begin
        n = $urandom_range(1, 11);
        while (frame_q.size() > n) void'(frame_q.pop_back());
      end else if (kind < 94) begin
        n = $urandom_range(1, 8);
        repeat (n) frame_q.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 16);
        frame_q.delete();
        repeat (n) frame_q.push_back(8'($urandom));
      end
      send_frame();
      frame_idx++;
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (chk.expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d accepted and %0d rejected frames,",
             bytes_sent, chk.ok_frames, chk.bad_frames);
    $display("including bad headers, bad checksums, short and overlong frames.");
    if (chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
